>>> hdl/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants of the stem-loop detector
// Field widths, table sizes, configuration indexes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int POS_W      = 12;
    localparam int ID_W       = 8;
    localparam int LAYER_W    = 4;
    localparam int N_LAYERS   = 8;
    localparam int LYR_W      = $clog2(N_LAYERS);
    localparam int MAX_LOOPS  = 32;
    localparam int LOOP_IDX_W = $clog2(MAX_LOOPS);
    localparam int CNT_W      = $clog2(MAX_LOOPS + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 1'd1;
    localparam logic [POS_W-1:0]     GAP_RESET      = 12'd19;
    localparam logic [POS_W-1:0]     DEPTH_MAX      = 12'd4095;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_STEM,
        S_WALK,
        S_TAIL,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic scan_inc;
        logic stem;
        logic idx_clr;
        logic walk_step;
        logic tail;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic need_check;
        logic scan_done;
        logic scan_hit;
        logic last;
        logic limit;
        logic walk_done;
        logic walk_emit;
        logic can_push;
        logic can_flush;
    } t_stat;

endpackage

>>> hdl/srd_in_if.sv
// ----------------------------------------------------------------------------
// srd_in_if: input channel of the stem-loop detector
// One base-pair table position per transfer.
// ----------------------------------------------------------------------------
interface srd_in_if;
    logic                     valid;
    logic                     ready;
    logic [11:0]              partner;
    logic signed [3:0]        pk_layer;
    logic                     last_base;

    modport source (output valid, partner, pk_layer, last_base, input ready);
    modport sink   (input valid, partner, pk_layer, last_base, output ready);
endinterface

>>> hdl/srd_out_if.sv
// ----------------------------------------------------------------------------
// srd_out_if: result channel of the stem-loop detector
// One detected region per transfer.
// ----------------------------------------------------------------------------
interface srd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  loop_id;
    logic [11:0] start_pos;
    logic [11:0] end_pos;
    logic        is_external;
    logic        table_full;
    logic        run_last;

    modport source (output valid, loop_id, start_pos, end_pos, is_external,
                    table_full, run_last, input ready);
    modport sink   (input valid, loop_id, start_pos, end_pos, is_external,
                    table_full, run_last, output ready);
endinterface

>>> hdl/srd_ctrl.sv
// ----------------------------------------------------------------------------
// srd_ctrl: sequencer of the stem-loop detector
// Steps one item through evaluation, containment scan, stem emission,
// the end-of-sequence walk and tail, and the final flush.
// ----------------------------------------------------------------------------
module srd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srd_pkg::t_stat i_stat,
    output srd_pkg::t_cmd  o_cmd
);

    srd_pkg::t_state r_state;
    srd_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            srd_pkg::S_IDLE: begin
                o_cmd.capture = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = srd_pkg::S_EVAL;
                end
            end
            srd_pkg::S_EVAL: begin
                o_cmd.eval    = 1'b1;
                o_cmd.idx_clr = 1'b1;
                if (i_stat.need_check) begin
                    n_state = srd_pkg::S_SCAN;
                end else if (i_stat.last && !i_stat.limit) begin
                    n_state = srd_pkg::S_WALK;
                end else begin
                    n_state = srd_pkg::S_FLUSH;
                end
            end
            srd_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = srd_pkg::S_STEM;
                end else if (i_stat.scan_hit) begin
                    if (i_stat.last && !i_stat.limit) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = srd_pkg::S_WALK;
                    end else begin
                        n_state = srd_pkg::S_FLUSH;
                    end
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            srd_pkg::S_STEM: begin
                if (i_stat.can_push) begin
                    o_cmd.stem = 1'b1;
                    if (i_stat.last && !i_stat.limit) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = srd_pkg::S_WALK;
                    end else begin
                        n_state = srd_pkg::S_FLUSH;
                    end
                end
            end
            srd_pkg::S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = srd_pkg::S_TAIL;
                end else if (!i_stat.walk_emit || i_stat.can_push) begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            srd_pkg::S_TAIL: begin
                if (i_stat.can_push) begin
                    o_cmd.tail = 1'b1;
                    n_state = srd_pkg::S_FLUSH;
                end
            end
            srd_pkg::S_FLUSH: begin
                if (i_stat.can_flush) begin
                    o_cmd.flush = 1'b1;
                    n_state = srd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/srd_dp.sv
// ----------------------------------------------------------------------------
// srd_dp: datapath of the stem-loop detector
// Holds configuration, per-layer nesting state, the loop table, counters,
// a pending result and the output register.
// ----------------------------------------------------------------------------
module srd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srd_pkg::t_cmd                       i_cmd,
    output srd_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_we,
    input  logic [srd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [srd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [srd_pkg::POS_W-1:0]           i_partner,
    input  logic [srd_pkg::LAYER_W-1:0]         i_pk_layer,
    input  logic                                i_last_base,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [srd_pkg::ID_W-1:0]            o_loop_id,
    output logic [srd_pkg::POS_W-1:0]           o_start_pos,
    output logic [srd_pkg::POS_W-1:0]           o_end_pos,
    output logic                                o_is_external,
    output logic                                o_table_full,
    output logic                                o_run_last
);

    localparam int PW = srd_pkg::POS_W;

    // Configuration.
    logic          r_limit;
    logic [PW-1:0] r_gap;

    // Captured item and sequence state.
    logic [PW-1:0]                 r_partner;
    logic [srd_pkg::LAYER_W-1:0]   r_layer;
    logic                          r_last;
    logic [PW-1:0]                 r_pos;
    logic [srd_pkg::ID_W-1:0]      r_id;
    logic [srd_pkg::CNT_W-1:0]     r_count;
    logic                          r_ovf;
    logic [PW-1:0]                 r_depth   [srd_pkg::N_LAYERS];
    logic                          r_closing [srd_pkg::N_LAYERS];
    logic [PW-1:0]                 r_pst     [srd_pkg::N_LAYERS];
    logic [PW-1:0]                 r_pen     [srd_pkg::N_LAYERS];
    logic [PW-1:0]                 r_ls      [srd_pkg::MAX_LOOPS];
    logic [PW-1:0]                 r_le      [srd_pkg::MAX_LOOPS];
    logic [PW-1:0]                 r_cs;
    logic [PW-1:0]                 r_ce;
    logic [srd_pkg::CNT_W-1:0]     r_i;
    logic [PW:0]                   r_wpos;

    // Pending result and output register.
    logic                          r_pend_v;
    logic [srd_pkg::ID_W-1:0]      r_pend_id;
    logic [PW-1:0]                 r_pend_s;
    logic [PW-1:0]                 r_pend_e;
    logic                          r_pend_x;
    logic                          r_pend_f;
    logic                          r_out_v;
    logic [srd_pkg::ID_W-1:0]      r_out_id;
    logic [PW-1:0]                 r_out_s;
    logic [PW-1:0]                 r_out_e;
    logic                          r_out_x;
    logic                          r_out_f;
    logic                          r_out_l;

    logic [srd_pkg::LYR_W-1:0]      li;
    logic                           lv;
    logic                           is_close;
    logic [srd_pkg::LOOP_IDX_W-1:0] ti;
    logic [PW+1:0]                  w_lim;
    logic [PW:0]                    len;
    logic                           tail_cond;
    logic                           table_full_now;
    logic                           push;
    logic [srd_pkg::ID_W-1:0]       push_id;
    logic [PW-1:0]                  push_s;
    logic [PW-1:0]                  push_e;
    logic                           push_x;
    logic                           push_f;
    logic                           out_free;

    // Item decode and status.
    always_comb begin
        li        = r_layer[srd_pkg::LYR_W-1:0];
        lv        = !r_layer[srd_pkg::LAYER_W-1];
        is_close  = r_partner < r_pos;
        ti        = r_i[srd_pkg::LOOP_IDX_W-1:0];
        w_lim     = {1'b0, r_wpos} + {2'b00, r_gap};
        len       = {1'b0, r_pos} + {{PW{1'b0}}, 1'b1};
        tail_cond = ({1'b0, len} > w_lim) || (r_count == '0);
        table_full_now = r_ovf || (r_count == srd_pkg::CNT_W'(srd_pkg::MAX_LOOPS));
        out_free  = !r_out_v || i_out_ready;

        o_stat.in_valid   = i_in_valid;
        o_stat.need_check = lv && (is_close ? (r_depth[li] == PW'(1))
                                            : (r_closing[li] && (r_depth[li] != '0)));
        o_stat.scan_done  = (r_i == r_count);
        o_stat.scan_hit   = (r_cs < r_ls[ti]) && (r_le[ti] < r_ce);
        o_stat.last       = r_last;
        o_stat.limit      = r_limit;
        o_stat.walk_done  = (r_i == r_count);
        o_stat.walk_emit  = {2'b00, r_ls[ti]} > w_lim;
        o_stat.can_push   = !r_pend_v || out_free;
        o_stat.can_flush  = !r_pend_v || out_free;
        o_in_ready        = i_cmd.capture;
    end

    // Selection of a new result.
    always_comb begin
        push    = 1'b0;
        push_id = r_id;
        push_s  = r_cs;
        push_e  = r_ce;
        push_x  = 1'b0;
        push_f  = r_ovf;
        if (i_cmd.stem) begin
            push   = 1'b1;
            push_f = table_full_now;
        end else if (i_cmd.walk_step && o_stat.walk_emit) begin
            push   = 1'b1;
            push_s = r_wpos[PW-1:0];
            push_e = r_ls[ti] - PW'(1);
            push_x = 1'b1;
        end else if (i_cmd.tail && tail_cond) begin
            push   = 1'b1;
            push_s = r_wpos[PW-1:0];
            push_e = r_pos;
            push_x = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 1'b0;
            r_gap   <= srd_pkg::GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srd_pkg::CFG_LIMIT_MODE: r_limit <= i_cfg_data[0];
                srd_pkg::CFG_MIN_GAP:    r_gap   <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_in_valid) begin
            r_partner <= i_partner;
            r_layer   <= i_pk_layer;
            r_last    <= i_last_base;
        end
    end

    // Per-layer nesting state, counters and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.flush && r_last)) begin
            for (int k = 0; k < srd_pkg::N_LAYERS; k++) begin
                r_depth[k]   <= '0;
                r_closing[k] <= 1'b0;
                r_pst[k]     <= '0;
                r_pen[k]     <= '0;
            end
            r_pos   <= '0;
            r_id    <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.eval && lv) begin
                if (is_close) begin
                    r_pst[li]     <= r_partner;
                    r_pen[li]     <= r_pos;
                    r_closing[li] <= 1'b1;
                    if (r_depth[li] != '0) begin
                        r_depth[li] <= r_depth[li] - PW'(1);
                    end
                end else if (r_closing[li]) begin
                    r_depth[li]   <= PW'(1);
                    r_closing[li] <= 1'b0;
                end else if (r_depth[li] != srd_pkg::DEPTH_MAX) begin
                    r_depth[li] <= r_depth[li] + PW'(1);
                end
            end
            if (i_cmd.stem) begin
                if (r_count == srd_pkg::CNT_W'(srd_pkg::MAX_LOOPS)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + srd_pkg::CNT_W'(1);
                end
            end
            if (push && !i_cmd.tail) begin
                r_id <= r_id + srd_pkg::ID_W'(1);
            end
            if (i_cmd.flush) begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    // Candidate bounds, loop table and scan index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            if (is_close) begin
                r_cs <= r_partner;
                r_ce <= r_pos;
            end else begin
                r_cs <= r_pst[li];
                r_ce <= r_pen[li];
            end
        end
        if (i_cmd.stem && (r_count != srd_pkg::CNT_W'(srd_pkg::MAX_LOOPS))) begin
            r_ls[r_count[srd_pkg::LOOP_IDX_W-1:0]] <= r_cs;
            r_le[r_count[srd_pkg::LOOP_IDX_W-1:0]] <= r_ce;
        end
        if (i_cmd.idx_clr) begin
            r_i    <= '0;
            r_wpos <= '0;
        end else if (i_cmd.scan_inc) begin
            r_i <= r_i + srd_pkg::CNT_W'(1);
        end else if (i_cmd.walk_step) begin
            r_i    <= r_i + srd_pkg::CNT_W'(1);
            r_wpos <= {1'b0, r_le[ti]} + {{PW{1'b0}}, 1'b1};
        end
    end

    // Pending result and output register: a new result pushes the held one out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if ((push || i_cmd.flush) && r_pend_v) begin
                r_out_v  <= 1'b1;
                r_out_id <= r_pend_id;
                r_out_s  <= r_pend_s;
                r_out_e  <= r_pend_e;
                r_out_x  <= r_pend_x;
                r_out_f  <= r_pend_f;
                r_out_l  <= i_cmd.flush;
            end
            if (push) begin
                r_pend_v  <= 1'b1;
                r_pend_id <= push_id;
                r_pend_s  <= push_s;
                r_pend_e  <= push_e;
                r_pend_x  <= push_x;
                r_pend_f  <= push_f;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_loop_id     = r_out_id;
    assign o_start_pos   = r_out_s;
    assign o_end_pos     = r_out_e;
    assign o_is_external = r_out_x;
    assign o_table_full  = r_out_f;
    assign o_run_last    = r_out_l;

endmodule

>>> hdl/rna_stemloop_detector_unit.sv
// ----------------------------------------------------------------------------
// rna_stemloop_detector_unit: RNA stem-loop and region detector
// Reads a base-pair table one position per transfer and reports closed
// stems and, at the end of a sequence, uncovered external regions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Moves
//  i_in      in         partner, pk_layer, last_base per position
//  o_out     out        loop_id, start_pos, end_pos, flags per region
//  i_cfg_*   in         register writes: 0 limit_mode, 1 min_region_gap
//
// An item passes capture, evaluation and flush. A closing stem is first checked
// against the loop table and emitted unless a recorded loop lies inside it; on
// the last position without limit mode the region walk and the tail follow.
// The loop table is scanned one entry per cycle by a single compare unit.
// Reset is synchronous; no clearing pass is needed. A stalled o_out holds
// the sequencer once one result is pending behind the output register.
// ----------------------------------------------------------------------------
module rna_stemloop_detector_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [srd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    srd_in_if.sink                         i_in,
    srd_out_if.source                      o_out
);

    srd_pkg::t_cmd  cmd;
    srd_pkg::t_stat stat;

    // Sequencer.
    srd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath.
    srd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_partner     (i_in.partner),
        .i_pk_layer    (i_in.pk_layer),
        .i_last_base   (i_in.last_base),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_loop_id     (o_out.loop_id),
        .o_start_pos   (o_out.start_pos),
        .o_end_pos     (o_out.end_pos),
        .o_is_external (o_out.is_external),
        .o_table_full  (o_out.table_full),
        .o_run_last    (o_out.run_last)
    );

endmodule

>>> tb/rna_stemloop_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_stemloop_detector_unit_tb: self-checking bench of the stem-loop detector
// A short table of hand-picked positions comes first, then random base-pair
// sequences and a full loop table. Every result transfer is compared with a
// behavioral predictor or a given region, under random stalls on both sides.
// ----------------------------------------------------------------------------
module rna_stemloop_detector_unit_tb;

    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic [7:0]  loop_id;
        logic [11:0] start_pos;
        logic [11:0] end_pos;
        logic        is_external;
        logic        table_full;
        logic        run_last;
    } t_region;

    typedef struct {
        logic [11:0]       partner;
        logic signed [3:0] layer;
        logic              last;
        logic              typed;
        t_region           region;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [srd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [srd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    srd_in_if  in_ch ();
    srd_out_if out_ch ();

    rna_stemloop_detector_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor copy of the registers and of the sequence state.
    logic        mdl_limit;
    int          mdl_gap;
    logic [11:0] mdl_depth [srd_pkg::N_LAYERS];
    logic        mdl_closing [srd_pkg::N_LAYERS];
    int          mdl_prev_s [srd_pkg::N_LAYERS];
    int          mdl_prev_e [srd_pkg::N_LAYERS];
    int          mdl_loop_s [srd_pkg::MAX_LOOPS];
    int          mdl_loop_e [srd_pkg::MAX_LOOPS];
    int          mdl_loops;
    logic [7:0]  mdl_id;
    int          mdl_pos;
    logic        mdl_overflow;

    t_region new_regions [$];
    t_region pending_regions [$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      no_idle = 1'b0;
    int      out_wait = 0;

    function automatic void clear_sequence();
        for (int l = 0; l < srd_pkg::N_LAYERS; l++) begin
            mdl_depth[l] = '0;
            mdl_closing[l] = 1'b0;
            mdl_prev_s[l] = 0;
            mdl_prev_e[l] = 0;
        end
        mdl_loops = 0;
        mdl_id = '0;
        mdl_pos = 0;
        mdl_overflow = 1'b0;
    endfunction

    function automatic bit inner_loop(int s, int e);
        for (int i = 0; i < mdl_loops; i++)
            if (s < mdl_loop_s[i] && mdl_loop_e[i] < e)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_region(int s, int e, logic ext);
        t_region r;
        r.loop_id = mdl_id;
        r.start_pos = s[11:0];
        r.end_pos = e[11:0];
        r.is_external = ext;
        r.table_full = mdl_overflow;
        r.run_last = 1'b0;
        new_regions.insert(new_regions.size(), r);
    endfunction

    function automatic void record_stem(int s, int e);
        if (mdl_loops < srd_pkg::MAX_LOOPS) begin
            mdl_loop_s[mdl_loops] = s;
            mdl_loop_e[mdl_loops] = e;
            mdl_loops++;
        end else begin
            mdl_overflow = 1'b1;
        end
        add_region(s, e, 1'b0);
        mdl_id++;
    endfunction

    // Works out the regions that one position produces into new_regions.
    function automatic void predict_regions(logic [11:0] partner, logic signed [3:0] layer,
                                            logic last);
        int p;
        int idx;
        int l;
        new_regions.delete();
        p = partner;
        idx = mdl_pos;
        l = layer[2:0];
        if (layer >= 0) begin
            if (p < idx) begin
                mdl_prev_s[l] = p;
                mdl_prev_e[l] = idx;
                mdl_closing[l] = 1'b1;
                if (mdl_depth[l] > 0) begin
                    mdl_depth[l]--;
                    if (mdl_depth[l] == 0 && !inner_loop(p, idx))
                        record_stem(p, idx);
                end
            end else if (mdl_closing[l]) begin
                if (mdl_depth[l] > 0 && !inner_loop(mdl_prev_s[l], mdl_prev_e[l]))
                    record_stem(mdl_prev_s[l], mdl_prev_e[l]);
                mdl_depth[l] = 12'd1;
                mdl_closing[l] = 1'b0;
            end else if (mdl_depth[l] < srd_pkg::DEPTH_MAX) begin
                mdl_depth[l]++;
            end
        end
        if (last) begin
            // Region walk over the recorded loops, then the tail region.
            if (!mdl_limit) begin
                int walk_pos;
                walk_pos = 0;
                for (int i = 0; i < mdl_loops; i++) begin
                    if (mdl_loop_s[i] > walk_pos + mdl_gap) begin
                        add_region(walk_pos, mdl_loop_s[i] - 1, 1'b1);
                        mdl_id++;
                    end
                    walk_pos = mdl_loop_e[i] + 1;
                end
                if (idx + 1 > walk_pos + mdl_gap || mdl_loops == 0)
                    add_region(walk_pos, idx, 1'b1);
            end
            clear_sequence();
        end else begin
            mdl_pos = (idx + 1) % 4096;
        end
        if (new_regions.size() > 0)
            new_regions[new_regions.size() - 1].run_last = 1'b1;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // Result side: random stalls and comparison with the oldest expectation.
    always @(posedge i_clk) begin
        t_region got;
        t_region want;
        logic    rdy;
        cycles <= cycles + 1;
        rdy = out_ch.ready;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.loop_id, out_ch.start_pos, out_ch.end_pos,
                   out_ch.is_external, out_ch.table_full, out_ch.run_last};
            if (pending_regions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected region transfer: %p", got);
            end else begin
                want = pending_regions.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("region mismatch: expected %p, actual %p", want, got);
                end
            end
            out_wait = draw_gap();
            rdy = (out_wait == 0);
        end else if (out_wait > 0) begin
            out_wait--;
            rdy = (out_wait == 0);
        end else begin
            rdy = 1'b1;
        end
        out_ch.ready <= rdy;
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sends one position and predicts its regions once the transfer happens.
    task automatic send_base(logic [11:0] partner, logic signed [3:0] layer, logic last,
                             bit typed = 1'b0, t_region region = '0);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.partner <= partner;
        in_ch.pk_layer <= layer;
        in_ch.last_base <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_regions(partner, layer, last);
        if (typed)
            pending_regions.insert(pending_regions.size(), region);
        else
            foreach (new_regions[i])
                pending_regions.insert(pending_regions.size(), new_regions[i]);
    endtask

    // Lets every expected region arrive, then waits out the block's latency.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_regions.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [srd_pkg::CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[11:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == srd_pkg::CFG_LIMIT_MODE)
            mdl_limit = value[0];
        else
            mdl_gap = value[11:0];
    endtask

    // One random sequence: nested stems over a few layers, plus noise.
    task automatic random_sequence(int len, int open_pct);
        int stack [srd_pkg::N_LAYERS][$];
        int l;
        int r;
        logic [11:0] partner;
        logic signed [3:0] layer;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
            if (r < 5) begin
                partner = 12'($urandom);
                layer = 4'($urandom);
            end else if (stack[l].size() > 0 && r < 100 - open_pct) begin
                partner = 12'(stack[l].pop_back());
                layer = 4'(l);
            end else if (r < 80) begin
                stack[l].insert(stack[l].size(), i % 4096);
                partner = 12'($urandom_range(4095, i % 4096));
                layer = 4'(l);
            end else begin
                partner = 12'($urandom);
                layer = 4'(-1 - $urandom_range(0, 7));
            end
            send_base(partner, layer, i == len - 1);
        end
    endtask

    t_row dir_rows [12];
    int   random_items;

    initial begin
        dir_rows = '{
            '{12'd0,    -4'sd1, 1'b1, 1'b1, '{8'd0, 12'd0, 12'd0, 1'b1, 1'b0, 1'b1}},
            '{12'd5,    4'sd0,  1'b0, 1'b0, '0},
            '{12'd4,    4'sd0,  1'b0, 1'b0, '0},
            '{12'd2,    4'sd0,  1'b0, 1'b0, '0},
            '{12'd4095, 4'sd7,  1'b0, 1'b0, '0},
            '{12'd1,    4'sd0,  1'b0, 1'b0, '0},
            '{12'd3,    4'sd7,  1'b0, 1'b1, '{8'd0, 12'd3, 12'd5, 1'b0, 1'b0, 1'b1}},
            '{12'd0,    4'sd0,  1'b0, 1'b0, '0},
            '{12'd0,    4'sd0,  1'b0, 1'b0, '0},
            '{12'd0,    4'sd3,  1'b0, 1'b0, '0},
            '{12'd4095, -4'sd8, 1'b0, 1'b0, '0},
            '{12'd0,    -4'sd1, 1'b1, 1'b0, '0}
        };
        in_ch.valid = 1'b0;
        in_ch.partner = '0;
        in_ch.pk_layer = '0;
        in_ch.last_base = 1'b0;
        mdl_limit = 1'b0;
        mdl_gap = int'(srd_pkg::GAP_RESET);
        clear_sequence();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hand-picked positions at reset register values.
        foreach (dir_rows[i])
            send_base(dir_rows[i].partner, dir_rows[i].layer, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].region);
        drain();

        // Small gap so external regions show up, with a burst of no idling.
        write_reg(srd_pkg::CFG_MIN_GAP, 0);
        no_idle = 1'b1;
        random_sequence(20, 50);
        no_idle = 1'b0;
        random_items = 20;
        while (random_items < 35) begin
            int len;
            len = $urandom_range(3, 15);
            random_sequence(len, $urandom_range(30, 60));
            random_items += len;
        end
        // More hairpins than the loop table holds.
        for (int i = 0; i < 33; i++) begin
            send_base(12'(2 * i + 1), 4'sd0, 1'b0);
            send_base(12'(2 * i), 4'sd0, 1'b0);
        end
        send_base(12'd0, -4'sd1, 1'b1);
        drain();

        // Limit mode with the widest gap.
        write_reg(srd_pkg::CFG_LIMIT_MODE, 1);
        write_reg(srd_pkg::CFG_MIN_GAP, 4095);
        while (random_items < 45) begin
            int len;
            len = $urandom_range(3, 15);
            random_sequence(len, 50);
            random_items += len;
        end
        drain();

        // Region walk back on, moderate gaps.
        write_reg(srd_pkg::CFG_LIMIT_MODE, 0);
        write_reg(srd_pkg::CFG_MIN_GAP, $urandom_range(1, 6));
        while (random_items < 55) begin
            int len;
            len = $urandom_range(3, 15);
            random_sequence(len, 45);
            random_items += len;
        end
        drain();

        if (mismatches == 0 && pending_regions.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
hdl/srd_pkg.sv
hdl/srd_in_if.sv
hdl/srd_out_if.sv
hdl/srd_ctrl.sv
hdl/srd_dp.sv
hdl/rna_stemloop_detector_unit.sv
tb/rna_stemloop_detector_unit_tb.sv
